/* design/stag_pkg.sv */
// shared types and constants of the strided tensor address generator
// no dependencies

package stag_pkg;

  localparam int NUM_OPERANDS = 3;
  localparam int OP_FIRST     = 0;
  localparam int OP_SECOND    = 1;
  localparam int OP_DEST      = 2;
  localparam int SLOT_BITS    = 3;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_NEXT = 1'b1
  } cmd_t;

  typedef struct packed {
    logic step;
    logic rewind;
  } cell_ctrl_t;

endpackage

/* design/stag_if.sv */
// valid/ready channel interfaces for command words and offset words
// depends on stag_pkg for the slot field width

interface stag_in_if #(
  parameter int SIZE_BITS   = 16,
  parameter int STRIDE_BITS = 24
);
  import stag_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [SLOT_BITS-1:0]     dim_slot;
  logic [SIZE_BITS-1:0]     dim_size;
  logic [STRIDE_BITS-1:0]   first_stride;
  logic [STRIDE_BITS-1:0]   second_stride;
  logic [STRIDE_BITS-1:0]   dest_stride;

  modport source (
    output valid, command, dim_slot, dim_size, first_stride, second_stride, dest_stride,
    input  ready
  );

  modport sink (
    input  valid, command, dim_slot, dim_size, first_stride, second_stride, dest_stride,
    output ready
  );
endinterface

interface stag_out_if #(
  parameter int OFFSET_BITS = 40
);
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] first_offset;
  logic [OFFSET_BITS-1:0] second_offset;
  logic [OFFSET_BITS-1:0] dest_offset;
  logic                   last;
  logic                   offset_overflow;

  modport source (
    output valid, first_offset, second_offset, dest_offset, last, offset_overflow,
    input  ready
  );

  modport sink (
    input  valid, first_offset, second_offset, dest_offset, last, offset_overflow,
    output ready
  );
endinterface

/* design/strided_tensor_address_generator_unit.sv */
// top level of the strided tensor address generator: cell row and output register
// depends on stag_pkg, stag_if and stag_cell
//
// in_if carries command words: a load word writes one dimension slot (size and
// three strides) and rewinds the walk to the origin; a load to a slot at or above
// NUM_DIMS is dropped. a next word emits the offset triple of the current position
// and advances the walk, the highest slot fastest. out_if carries one offset word
// per emitted element, with last on the final element of the walk and
// offset_overflow when a true offset left the field range. next words after the
// last element, or while any size is zero, emit nothing until a load rewinds.
// out_if.valid rises in the cycle after an accepted next word. one word is
// taken every cycle: each cell advances its position with one add per operand in
// the same cycle, and the output register frees in_if.ready whenever it is empty
// or being drained. when out_if stalls with a word held, in_if.ready drops until
// the word is taken. after reset all sizes are one, all strides zero and the walk
// sits at the origin.

module strided_tensor_address_generator_unit import stag_pkg::*; #(
  parameter int NUM_DIMS    = 8,
  parameter int SIZE_BITS   = 16,
  parameter int STRIDE_BITS = 24,
  parameter int OFFSET_BITS = 40
) (
  input  logic       clk,
  input  logic       rst_n,
  stag_in_if.sink    in_if,
  stag_out_if.source out_if
);

  localparam logic [SLOT_BITS:0] DIM_LIMIT = (SLOT_BITS+1)'(NUM_DIMS);

  cell_ctrl_t                                     ctrl;
  logic [NUM_DIMS:0]                              wrap;
  logic [NUM_DIMS:0][NUM_OPERANDS-1:0][OFFSET_BITS:0] base_link;
  logic [NUM_DIMS-1:0][NUM_OPERANDS-1:0][OFFSET_BITS:0] base_cur;
  logic [NUM_DIMS-1:0]                            zero;
  logic [NUM_OPERANDS-1:0][STRIDE_BITS-1:0]       wr_stride;
  logic [NUM_OPERANDS-1:0][OFFSET_BITS:0]         cur;

  logic                   accept;
  logic                   is_next;
  logic                   slot_ok;
  logic                   emit;
  logic                   is_last;
  logic                   finished_r, finished_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OFFSET_BITS-1:0] out_first_r, out_second_r, out_dest_r;
  logic                   out_last_r, out_over_r;

  assign accept  = in_if.valid & in_if.ready;
  assign is_next = (in_if.command == CMD_NEXT);
  assign slot_ok = {1'b0, in_if.dim_slot} < DIM_LIMIT;
  assign is_last = wrap[0];
  assign emit    = accept & is_next & ~finished_r & ~(|zero);

  assign ctrl.step   = emit & ~is_last;
  assign ctrl.rewind = accept & ~is_next & slot_ok;

  assign wr_stride[OP_FIRST]  = in_if.first_stride;
  assign wr_stride[OP_SECOND] = in_if.second_stride;
  assign wr_stride[OP_DEST]   = in_if.dest_stride;

  assign wrap[NUM_DIMS] = 1'b1;
  assign base_link[0]   = '0;
  assign cur            = base_cur[NUM_DIMS-1];

  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_cell
    stag_cell #(
      .SIZE_BITS   (SIZE_BITS),
      .STRIDE_BITS (STRIDE_BITS),
      .OFFSET_BITS (OFFSET_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .wr_en     (ctrl.rewind & (in_if.dim_slot == SLOT_BITS'(d))),
      .wr_size   (in_if.dim_size),
      .wr_stride (wr_stride),
      .wrap_in   (wrap[d+1]),
      .wrap_out  (wrap[d]),
      .base_in   (base_link[d]),
      .base_out  (base_link[d+1]),
      .base_cur  (base_cur[d]),
      .size_zero (zero[d])
    );
  end

  assign in_if.ready = ~out_valid_r | out_if.ready;

  always_comb begin
    finished_nxt = finished_r;
    if (ctrl.rewind) begin
      finished_nxt = 1'b0;
    end else if (emit & is_last) begin
      finished_nxt = 1'b1;
    end
    out_valid_nxt = emit | (out_valid_r & ~out_if.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_first_r  <= cur[OP_FIRST][OFFSET_BITS-1:0];
      out_second_r <= cur[OP_SECOND][OFFSET_BITS-1:0];
      out_dest_r   <= cur[OP_DEST][OFFSET_BITS-1:0];
      out_last_r   <= is_last;
      out_over_r   <= cur[OP_FIRST][OFFSET_BITS] | cur[OP_SECOND][OFFSET_BITS]
                      | cur[OP_DEST][OFFSET_BITS];
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.first_offset    = out_first_r;
  assign out_if.second_offset   = out_second_r;
  assign out_if.dest_offset     = out_dest_r;
  assign out_if.last            = out_last_r;
  assign out_if.offset_overflow = out_over_r;

endmodule

/* design/stag_cell.sv */
// one dimension of the walk: size, strides, position and prefix offsets
// depends on stag_pkg

module stag_cell import stag_pkg::*; #(
  parameter int SIZE_BITS   = 16,
  parameter int STRIDE_BITS = 24,
  parameter int OFFSET_BITS = 40
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  cell_ctrl_t                               ctrl,
  input  logic                                     wr_en,
  input  logic [SIZE_BITS-1:0]                     wr_size,
  input  logic [NUM_OPERANDS-1:0][STRIDE_BITS-1:0] wr_stride,
  input  logic                                     wrap_in,
  output logic                                     wrap_out,
  input  logic [NUM_OPERANDS-1:0][OFFSET_BITS:0]   base_in,
  output logic [NUM_OPERANDS-1:0][OFFSET_BITS:0]   base_out,
  output logic [NUM_OPERANDS-1:0][OFFSET_BITS:0]   base_cur,
  output logic                                     size_zero
);

  localparam int ADD_BITS = (OFFSET_BITS > STRIDE_BITS ? OFFSET_BITS : STRIDE_BITS) + 1;

  logic [SIZE_BITS-1:0]                     size_r, size_nxt;
  logic [SIZE_BITS-1:0]                     idx_r, idx_nxt;
  logic [NUM_OPERANDS-1:0][STRIDE_BITS-1:0] stride_r, stride_nxt;
  logic [NUM_OPERANDS-1:0][OFFSET_BITS:0]   base_r, base_nxt;
  logic [NUM_OPERANDS-1:0][ADD_BITS-1:0]    sum;
  logic [NUM_OPERANDS-1:0][OFFSET_BITS:0]   stepped;
  logic                                     wrap_here;
  logic                                     inc;
  logic                                     clr;

  assign wrap_here = ({1'b0, idx_r} + (SIZE_BITS+1)'(1)) >= {1'b0, size_r};
  assign wrap_out  = wrap_in & wrap_here;
  assign inc       = ctrl.step & wrap_in & ~wrap_here;
  assign clr       = ctrl.step & wrap_in & wrap_here;
  assign size_zero = (size_r == '0);
  assign base_out  = base_nxt;
  assign base_cur  = base_r;

  always_comb begin
    size_nxt   = wr_en ? wr_size : size_r;
    stride_nxt = wr_en ? wr_stride : stride_r;

    if (ctrl.rewind) begin
      idx_nxt = '0;
    end else if (inc) begin
      idx_nxt = idx_r + SIZE_BITS'(1);
    end else if (clr) begin
      idx_nxt = '0;
    end else begin
      idx_nxt = idx_r;
    end

    for (int op = 0; op < NUM_OPERANDS; op++) begin
      // overflow bit is sticky once any partial sum left the field range
      sum[op]     = ADD_BITS'(base_r[op][OFFSET_BITS-1:0]) + ADD_BITS'(stride_r[op]);
      stepped[op] = {base_r[op][OFFSET_BITS] | ((sum[op] >> OFFSET_BITS) != '0),
                     sum[op][OFFSET_BITS-1:0]};
      if (ctrl.rewind) begin
        base_nxt[op] = '0;
      end else if (inc) begin
        base_nxt[op] = stepped[op];
      end else if (clr) begin
        base_nxt[op] = base_in[op];
      end else begin
        base_nxt[op] = base_r[op];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= SIZE_BITS'(1);
      idx_r    <= '0;
      stride_r <= '0;
      base_r   <= '0;
    end else begin
      size_r   <= size_nxt;
      idx_r    <= idx_nxt;
      stride_r <= stride_nxt;
      base_r   <= base_nxt;
    end
  end

endmodule

/* design/stag_checker.sv */
// port-level checks on the strided tensor address generator, bound to the top level
// depends on stag_pkg and strided_tensor_address_generator_unit

module stag_checker import stag_pkg::*; #(
  parameter int OFFSET_BITS = 40
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_command,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [OFFSET_BITS-1:0] out_first_offset,
  input logic                   out_last
);

  // an empty output register always takes a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  // a load word never produces an offset word
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_LOAD && !out_valid |=> !out_valid)
    else $error("offset word after load");

  a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_first_offset) && $stable(out_last))
    else $error("offset word changed while stalled");

endmodule

bind strided_tensor_address_generator_unit stag_checker #(
  .OFFSET_BITS (OFFSET_BITS)
) u_stag_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .in_command       (in_if.command),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_first_offset (out_if.first_offset),
  .out_last         (out_if.last)
);

/* verif/tb.sv */
// testbench for strided_tensor_address_generator_unit: drives command words, predicts
// each offset word of the eight-dimensional walk and checks every word the block emits
// depends on stag_pkg, stag_if and the design sources

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stag_pkg::*;

  localparam int DIMS       = 8;
  localparam int SIZE_W     = 16;
  localparam int STRIDE_W   = 24;
  localparam int OFFSET_W   = 40;
  localparam int RAND_WORDS = 2000;

  localparam logic [STRIDE_W-1:0] STRIDE_MAX = {STRIDE_W{1'b1}};
  localparam logic [SIZE_W-1:0]   SIZE_MAX   = {SIZE_W{1'b1}};

  typedef struct packed {
    cmd_t                  cmd;
    logic [SLOT_BITS-1:0]  slot;
    logic [SIZE_W-1:0]     size;
    logic [STRIDE_W-1:0]   first_stride;
    logic [STRIDE_W-1:0]   second_stride;
    logic [STRIDE_W-1:0]   dest_stride;
  } cmd_word_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] first_offset;
    logic [OFFSET_W-1:0] second_offset;
    logic [OFFSET_W-1:0] dest_offset;
    logic                last;
    logic                offset_overflow;
  } offset_word_t;

  logic clk;
  logic rst_n;

  stag_in_if  #(.SIZE_BITS(SIZE_W), .STRIDE_BITS(STRIDE_W)) in_ch ();
  stag_out_if #(.OFFSET_BITS(OFFSET_W))                     out_ch ();

  strided_tensor_address_generator_unit #(
    .NUM_DIMS    (DIMS),
    .SIZE_BITS   (SIZE_W),
    .STRIDE_BITS (STRIDE_W),
    .OFFSET_BITS (OFFSET_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  // walk state as the block should hold it
  logic [SIZE_W-1:0]   slot_size   [DIMS];
  logic [STRIDE_W-1:0] slot_stride [NUM_OPERANDS][DIMS];
  logic [SIZE_W-1:0]   slot_pos    [DIMS];
  bit                  walk_done;

  offset_word_t pending_offsets [$];
  int           errors;
  int           words_sent;
  bit           tx_idle_en;
  bit           rx_idle_en;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void clear_walk_model();
    foreach (slot_size[d]) begin
      slot_size[d] = SIZE_W'(1);
      slot_pos[d]  = '0;
      for (int op = 0; op < NUM_OPERANDS; op++) slot_stride[op][d] = '0;
    end
    walk_done = 1'b0;
  endfunction

  function automatic void predict_offsets(input cmd_word_t w);
    offset_word_t        o;
    logic [63:0]         total;
    logic [OFFSET_W-1:0] offs [NUM_OPERANDS];
    bit                  at_end;
    bit                  over;
    if (w.cmd == CMD_LOAD) begin
      slot_size[w.slot]             = w.size;
      slot_stride[OP_FIRST][w.slot]  = w.first_stride;
      slot_stride[OP_SECOND][w.slot] = w.second_stride;
      slot_stride[OP_DEST][w.slot]   = w.dest_stride;
      foreach (slot_pos[d]) slot_pos[d] = '0;
      walk_done = 1'b0;
      return;
    end
    if (walk_done) return;
    foreach (slot_size[d]) if (slot_size[d] == '0) return;
    at_end = 1'b1;
    foreach (slot_pos[d]) if (32'(slot_pos[d]) + 1 != 32'(slot_size[d])) at_end = 1'b0;
    over = 1'b0;
    for (int op = 0; op < NUM_OPERANDS; op++) begin
      total = '0;
      for (int d = 0; d < DIMS; d++) total += 64'(slot_pos[d]) * 64'(slot_stride[op][d]);
      if ((total >> OFFSET_W) != 0) over = 1'b1;
      offs[op] = total[OFFSET_W-1:0];
    end
    o.first_offset    = offs[OP_FIRST];
    o.second_offset   = offs[OP_SECOND];
    o.dest_offset     = offs[OP_DEST];
    o.last            = at_end;
    o.offset_overflow = over;
    pending_offsets.push_back(o);
    if (at_end) begin
      walk_done = 1'b1;
    end else begin
      for (int d = DIMS - 1; d >= 0; d--) begin
        if (32'(slot_pos[d]) + 1 < 32'(slot_size[d])) begin
          slot_pos[d]++;
          break;
        end
        slot_pos[d] = '0;
      end
    end
  endfunction

  task automatic send_word(input cmd_word_t w);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= w.cmd;
    in_ch.dim_slot      <= w.slot;
    in_ch.dim_size      <= w.size;
    in_ch.first_stride  <= w.first_stride;
    in_ch.second_stride <= w.second_stride;
    in_ch.dest_stride   <= w.dest_stride;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_offsets(w);
    words_sent++;
  endtask

  task automatic load_slot(input int slot, input logic [SIZE_W-1:0] size,
                           input logic [STRIDE_W-1:0] s_first, s_second, s_dest);
    cmd_word_t w;
    w.cmd           = CMD_LOAD;
    w.slot          = SLOT_BITS'(slot);
    w.size          = size;
    w.first_stride  = s_first;
    w.second_stride = s_second;
    w.dest_stride   = s_dest;
    send_word(w);
  endtask

  // unused fields of a next word carry random bits
  task automatic next_word();
    cmd_word_t w;
    w               = cmd_word_t'({$urandom, $urandom, $urandom, $urandom});
    w.cmd           = CMD_NEXT;
    send_word(w);
  endtask

  task automatic wait_offsets_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_offsets.size() != 0);
  endtask

  function automatic logic [STRIDE_W-1:0] pick_stride();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return STRIDE_MAX;
      2:       return STRIDE_W'($urandom_range(0, 15));
      default: return STRIDE_W'($urandom);
    endcase
  endfunction

  // offset word receiver and checker
  initial begin
    offset_word_t got;
    offset_word_t want;
    int           stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_idle_en ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.first_offset    = out_ch.first_offset;
      got.second_offset   = out_ch.second_offset;
      got.dest_offset     = out_ch.dest_offset;
      got.last            = out_ch.last;
      got.offset_overflow = out_ch.offset_overflow;
      if (pending_offsets.size() == 0) begin
        errors++;
        $display("%0t: unexpected offset word %h %h %h last %b ovf %b", $time,
                 got.first_offset, got.second_offset, got.dest_offset,
                 got.last, got.offset_overflow);
      end else begin
        want = pending_offsets.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: expected %h %h %h last %b ovf %b, got %h %h %h last %b ovf %b",
                   $time, want.first_offset, want.second_offset, want.dest_offset,
                   want.last, want.offset_overflow, got.first_offset, got.second_offset,
                   got.dest_offset, got.last, got.offset_overflow);
        end
      end
    end
  end

  // origin after reset is a one-element walk; a second next finds it ended
  task automatic test_reset_walk();
    next_word();
    next_word();
    wait_offsets_drained();
  endtask

  // extreme strides, walk end, empty walk and a rewind out of it
  task automatic test_walk_extremes();
    load_slot(0, SIZE_W'(2), STRIDE_MAX, STRIDE_W'(24'hAAAAAA), '0);
    load_slot(7, SIZE_W'(3), STRIDE_MAX, STRIDE_W'(1), STRIDE_W'(24'h555555));
    repeat (7) next_word();
    load_slot(3, SIZE_W'(0), STRIDE_MAX, STRIDE_MAX, STRIDE_MAX);
    repeat (2) next_word();
    load_slot(3, SIZE_MAX, STRIDE_MAX, '0, STRIDE_MAX);
    repeat (3) next_word();
  endtask

  task automatic test_random_walks();
    int                sizes [DIMS];
    int                target;
    int                elems;
    int                rot;
    int                s;
    cmd_word_t         w;
    target = words_sent + RAND_WORDS;
    while (words_sent < target) begin
      tx_idle_en = ($urandom_range(0, 4) != 0);
      rx_idle_en = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          w = cmd_word_t'({$urandom, $urandom, $urandom, $urandom});
          if ($urandom_range(0, 2) == 0) w.size = SIZE_W'($urandom_range(0, 3));
          send_word(w);
        end
      end else begin
        foreach (sizes[d]) sizes[d] = 1;
        repeat ($urandom_range(0, 3)) sizes[$urandom_range(0, DIMS - 1)] = $urandom_range(2, 4);
        if ($urandom_range(0, 11) == 0) sizes[$urandom_range(0, DIMS - 1)] = 0;
        if ($urandom_range(0, 11) == 0) sizes[$urandom_range(0, DIMS - 1)] = int'(SIZE_MAX);
        rot = $urandom_range(0, DIMS - 1);
        for (int i = 0; i < DIMS; i++) begin
          s = (i + rot) % DIMS;
          load_slot(s, SIZE_W'(sizes[s]), pick_stride(), pick_stride(), pick_stride());
        end
        elems = 1;
        foreach (sizes[d]) elems = (elems * sizes[d] > 80) ? 80 : elems * sizes[d];
        repeat (elems + $urandom_range(0, 2)) next_word();
      end
      if ($urandom_range(0, 9) == 0) wait_offsets_drained();
    end
  endtask

  initial begin
    errors     = 0;
    words_sent = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    clear_walk_model();
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_LOAD;
    in_ch.dim_slot      <= '0;
    in_ch.dim_size      <= '0;
    in_ch.first_stride  <= '0;
    in_ch.second_stride <= '0;
    in_ch.dest_stride   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_walk();
    test_walk_extremes();
    test_random_walks();

    wait_offsets_drained();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
